[rtl/shfp_pkg.sv]
// ----------------------------------------------------------------------------
// shfp_pkg
// shared types, constants and packing for the sync header frame parser
// ----------------------------------------------------------------------------
package shfp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned PosW       = 5;
  localparam int unsigned PayloadLen = 13;
  localparam int unsigned ResultBits = 107;
  localparam int unsigned OutDataW   = 112;

  localparam logic [ByteW-1:0] SyncFirst  = 8'hAA;
  localparam logic [ByteW-1:0] SyncSecond = 8'h55;
  localparam logic [ByteW-1:0] FooterByte = 8'h5B;
  localparam logic [ByteW-1:0] ColorType  = 8'h03;

  localparam logic [PosW-1:0] PosHunt    = 5'd0;
  localparam logic [PosW-1:0] PosSync2   = 5'd1;
  localparam logic [PosW-1:0] PosFirstPl = 5'd2;
  localparam logic [PosW-1:0] PosLastPl  = 5'd14;
  localparam logic [PosW-1:0] PosCheck   = 5'd15;
  localparam logic [PosW-1:0] PosFooter  = 5'd16;

  typedef enum logic [1:0] {
    STATUS_GOOD         = 2'd0,
    STATUS_BAD_FOOTER   = 2'd1,
    STATUS_BAD_CHECKSUM = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  frame_type;
    logic [15:0] sequence_res;
    logic [7:0]  flags;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0] pixel_count;
    logic [15:0] rate_tenths;
    logic [7:0]  mean_level;
    logic        is_color_frame;
  } result_t;

  function automatic logic [OutDataW-1:0] pack_result(input result_t r);
    logic [OutDataW-1:0] d;
    d = '0;
    d[1:0]     = r.status;
    d[9:2]     = r.frame_type;
    d[25:10]   = r.sequence_res;
    d[33:26]   = r.flags;
    d[49:34]   = r.center_x;
    d[65:50]   = r.center_y;
    d[81:66]   = r.pixel_count;
    d[97:82]   = r.rate_tenths;
    d[105:98]  = r.mean_level;
    d[106]     = r.is_color_frame;
    return d;
  endfunction

endpackage

[rtl/shfp_parser.sv]
// ----------------------------------------------------------------------------
// shfp_parser
// input register, frame position tracking, payload store and frame judging
// ----------------------------------------------------------------------------
module shfp_parser
  import shfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [ByteW-1:0] s_tdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             out_free,
  output logic             res_load,
  output result_t          res
);

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic [PosW-1:0]  byte_position;
  logic [PosW-1:0]  byte_position_next;
  logic [ByteW-1:0] payload_store [PayloadLen];
  logic [ByteW-1:0] running_xor;
  logic [ByteW-1:0] running_xor_next;
  logic [ByteW-1:0] check_byte;
  logic             at_footer;
  logic             advance;
  logic             is_payload;

  assign at_footer  = (byte_position == PosFooter);
  assign is_payload = (byte_position >= PosFirstPl) && (byte_position <= PosLastPl);
  assign advance    = in_valid && (!at_footer || out_free);
  assign s_tready   = !in_valid || advance;
  assign res_load   = in_valid && at_footer && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    running_xor_next   = running_xor;
    if (byte_position == PosSync2) begin
      if (in_byte == SyncSecond) begin
        running_xor_next   = '0;
        byte_position_next = PosFirstPl;
      end else begin
        byte_position_next = (in_byte == SyncFirst) ? PosSync2 : PosHunt;
      end
    end else if (is_payload) begin
      running_xor_next   = running_xor ^ in_byte;
      byte_position_next = byte_position + 5'd1;
    end else if (byte_position == PosCheck) begin
      byte_position_next = PosFooter;
    end else if (at_footer) begin
      byte_position_next = PosHunt;
    end else begin
      byte_position_next = (in_byte == SyncFirst) ? PosSync2 : PosHunt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= PosHunt;
      running_xor   <= '0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      running_xor   <= running_xor_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PayloadLen; i++) begin
      if (advance && byte_position == PosW'(i + 2)) begin
        payload_store[i] <= in_byte;
      end
    end
    if (advance && byte_position == PosCheck) begin
      check_byte <= in_byte;
    end
  end

  always_comb begin
    res = '0;
    if (in_byte != FooterByte) begin
      res.status = STATUS_BAD_FOOTER;
    end else if (check_byte != running_xor) begin
      res.status = STATUS_BAD_CHECKSUM;
    end else begin
      res.status         = STATUS_GOOD;
      res.frame_type     = payload_store[0];
      res.sequence_res   = {payload_store[2], payload_store[1]};
      res.flags          = payload_store[3];
      res.center_x       = {payload_store[5], payload_store[4]};
      res.center_y       = {payload_store[7], payload_store[6]};
      res.pixel_count    = {payload_store[9], payload_store[8]};
      res.rate_tenths    = {payload_store[11], payload_store[10]};
      res.mean_level     = payload_store[12];
      res.is_color_frame = (payload_store[0] == ColorType);
    end
  end

endmodule

[rtl/shfp_out_reg.sv]
// ----------------------------------------------------------------------------
// shfp_out_reg
// result register driving the output stream
// ----------------------------------------------------------------------------
module shfp_out_reg
  import shfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                res_load,
  input  result_t             res,
  output logic                out_free,
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tvalid,
  input  logic                m_tready
);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_load;
    end
    if (res_load) begin
      m_tdata <= pack_result(res);
    end
  end

endmodule

[rtl/sync_header_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// sync_header_frame_parser_top
// finds 0xAA 0x55 framed 17-byte packets, checks footer and xor, decodes fields
// ----------------------------------------------------------------------------
// the footer byte passes the input register, and its result is loaded into the output register
// one byte per cycle, held by output stalls at a footer; set by input reg and xor
// a result is produced only for the footer byte of a synchronized frame
// reset: synchronous rst returns the parser to header hunting, clears xor and
//   empties both register stages; the payload store is not cleared
module sync_header_frame_parser_top
  import shfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [ByteW-1:0]    s_tdata,   // rx_byte[7:0]
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic [OutDataW-1:0] m_tdata,   // status[1:0], frame_type[9:2],
                                         // sequence_res[25:10], flags[33:26],
                                         // center_x[49:34], center_y[65:50],
                                         // pixel_count[81:66], rate_tenths[97:82],
                                         // mean_level[105:98], is_color_frame[106]
  output logic                m_tvalid,
  input  logic                m_tready
);

  logic    out_free;
  logic    res_load;
  result_t res;

  shfp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  shfp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .res_load (res_load),
    .res      (res),
    .out_free (out_free),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

endmodule

[rtl/shfp_checker.sv]
// ----------------------------------------------------------------------------
// shfp_checker
// port level checks on the result stream of the frame parser
// ----------------------------------------------------------------------------
module shfp_checker
  import shfp_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic [OutDataW-1:0] m_tdata,
  input logic                m_tvalid,
  input logic                m_tready
);

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result request dropped while stalled");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("invalid status code");

  a_bad_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != STATUS_GOOD |-> m_tdata[OutDataW-1:2] == '0)
    else $error("bad frame carries nonzero fields");

  a_color : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[106] |-> m_tdata[9:2] == ColorType && m_tdata[1:0] == STATUS_GOOD)
    else $error("color flag without good color frame");

  a_pad_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OutDataW-1:ResultBits] == '0)
    else $error("padding bits not zero");

endmodule

bind sync_header_frame_parser_top shfp_checker u_shfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
